@@ rtl/bst_pkg.sv @@
// Shared constants, codes, handshake structs and helpers for the breakpoint slot table.
package bst_pkg;

	// Table geometry
	localparam int MEM_SLOTS   = 10;
	localparam int HW_SLOTS    = 10;
	localparam int WATCH_SLOTS = 16;
	localparam int LANES       = 16;
	localparam int SLOT_W      = 4;
	localparam int CNT_W       = 5;

	// Field widths
	localparam int KIND_W      = 2;
	localparam int TYPE_W      = 3;
	localparam int ADDR_W      = 32;
	localparam int SIZE_W      = 32;
	localparam int HW_CNT_W    = 4;
	localparam int WATCH_CNT_W = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// Breakpoint types
	localparam logic [TYPE_W-1:0] BT_MEMORY   = 3'd0;
	localparam logic [TYPE_W-1:0] BT_HARDWARE = 3'd1;
	localparam logic [TYPE_W-1:0] BT_WRITE    = 3'd2;
	localparam logic [TYPE_W-1:0] BT_READ     = 3'd3;
	localparam logic [TYPE_W-1:0] BT_ACCESS   = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HW_SLOTS    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WATCH_SLOTS = 1'd1;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic search;
		logic update;
	} bst_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic no_search;
	} bst_status_t;

	// Lowest set lane of a match vector
	function automatic logic [SLOT_W-1:0] lowest_slot(input logic [LANES-1:0] v);
		logic [SLOT_W-1:0] idx;
		idx = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ rtl/bst_dp.sv @@
// Datapath: slot tables, parallel address search, table update and result register.
module bst_dp import bst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bst_cmd_t               cmd,
	output bst_status_t            status,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [KIND_W-1:0]      kind,
	input  logic [TYPE_W-1:0]      break_type,
	input  logic [ADDR_W-1:0]      target_address,
	input  logic [SIZE_W-1:0]      watch_size,
	output logic                   success,
	output logic [SLOT_W-1:0]      slot_index
);

	logic [HW_CNT_W-1:0]    hw_cnt_q;
	logic [WATCH_CNT_W-1:0] watch_cnt_q;

	logic [KIND_W-1:0] kind_q;
	logic [TYPE_W-1:0] type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;

	logic [MEM_SLOTS-1:0]   mem_valid_q;
	logic [ADDR_W-1:0]      mem_addr_q [MEM_SLOTS];
	logic [HW_SLOTS-1:0]    hw_valid_q;
	logic [ADDR_W-1:0]      hw_addr_q [HW_SLOTS];
	logic [WATCH_SLOTS-1:0] watch_valid_q;
	logic [ADDR_W-1:0]      watch_addr_q [WATCH_SLOTS];
	logic [SIZE_W-1:0]      watch_ext_q [WATCH_SLOTS];
	logic [TYPE_W-1:0]      watch_kind_q [WATCH_SLOTS];

	logic [CNT_W-1:0]  hw_lim, watch_lim;
	logic [LANES-1:0]  hit_v, free_v;
	logic              hit_any_q, free_any_q;
	logic [SLOT_W-1:0] hit_idx_q, free_idx_q;

	logic              type_ok, is_watch, do_insert, do_remove, do_clear;
	logic              take_free, merge, drop, ok;
	logic [SLOT_W-1:0] slot;

	// Commands that touch no table skip the search
	assign status.no_search = (kind != KIND_INSERT && kind != KIND_REMOVE) ||
		(break_type > BT_ACCESS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_cnt_q    <= '0;
			watch_cnt_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HW_SLOTS:    hw_cnt_q    <= cfg_data[HW_CNT_W-1:0];
				CFG_WATCH_SLOTS: watch_cnt_q <= cfg_data[WATCH_CNT_W-1:0];
				default:         ;
			endcase
		end
	end

	// Command word capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			type_q <= break_type;
			addr_q <= target_address;
			size_q <= watch_size;
		end
	end

	// Enabled counts saturate at table size
	assign hw_lim = (CNT_W'(hw_cnt_q) > CNT_W'(HW_SLOTS)) ? CNT_W'(HW_SLOTS) :
		CNT_W'(hw_cnt_q);
	assign watch_lim = (CNT_W'(watch_cnt_q) > CNT_W'(WATCH_SLOTS)) ? CNT_W'(WATCH_SLOTS) :
		CNT_W'(watch_cnt_q);

	// Parallel compare of the selected table
	always_comb begin
		hit_v  = '0;
		free_v = '0;
		case (type_q)
			BT_MEMORY: begin
				for (int i = 0; i < MEM_SLOTS; i++) begin
					hit_v[i]  = mem_valid_q[i] && (mem_addr_q[i] == addr_q);
					free_v[i] = !mem_valid_q[i];
				end
			end
			BT_HARDWARE: begin
				for (int i = 0; i < HW_SLOTS; i++) begin
					hit_v[i]  = (CNT_W'(i) < hw_lim) && hw_valid_q[i] &&
						(hw_addr_q[i] == addr_q);
					free_v[i] = (CNT_W'(i) < hw_lim) && !hw_valid_q[i];
				end
			end
			default: begin
				for (int i = 0; i < WATCH_SLOTS; i++) begin
					hit_v[i]  = (CNT_W'(i) < watch_lim) && watch_valid_q[i] &&
						(watch_addr_q[i] == addr_q);
					free_v[i] = (CNT_W'(i) < watch_lim) && !watch_valid_q[i];
				end
			end
		endcase
	end

	// Search result registers
	always_ff @(posedge clk) begin
		if (cmd.search) begin
			hit_any_q  <= |hit_v;
			hit_idx_q  <= lowest_slot(hit_v);
			free_any_q <= |free_v;
			free_idx_q <= lowest_slot(free_v);
		end
	end

	// Update decode
	assign type_ok   = (type_q <= BT_ACCESS);
	assign is_watch  = (type_q == BT_WRITE) || (type_q == BT_READ) || (type_q == BT_ACCESS);
	assign do_insert = (kind_q == KIND_INSERT) && type_ok;
	assign do_remove = (kind_q == KIND_REMOVE) && type_ok;
	assign do_clear  = (kind_q == KIND_CLEAR);
	assign take_free = do_insert && !hit_any_q && free_any_q;
	assign merge     = do_insert && hit_any_q && is_watch;
	assign drop      = do_remove && hit_any_q;
	assign ok        = do_clear || ((do_insert || do_remove) && hit_any_q) || take_free;
	assign slot      = (do_clear || !ok) ? '0 : (hit_any_q ? hit_idx_q : free_idx_q);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q   <= '0;
			hw_valid_q    <= '0;
			watch_valid_q <= '0;
		end else if (cmd.update) begin
			if (do_clear) begin
				mem_valid_q   <= '0;
				hw_valid_q    <= '0;
				watch_valid_q <= '0;
			end else if (take_free) begin
				case (type_q)
					BT_MEMORY:   mem_valid_q[free_idx_q]   <= 1'b1;
					BT_HARDWARE: hw_valid_q[free_idx_q]    <= 1'b1;
					default:     watch_valid_q[free_idx_q] <= 1'b1;
				endcase
			end else if (drop) begin
				case (type_q)
					BT_MEMORY:   mem_valid_q[hit_idx_q]   <= 1'b0;
					BT_HARDWARE: hw_valid_q[hit_idx_q]    <= 1'b0;
					default:     watch_valid_q[hit_idx_q] <= 1'b0;
				endcase
			end
		end
	end

	// Entry payloads
	always_ff @(posedge clk) begin
		if (cmd.update && take_free) begin
			case (type_q)
				BT_MEMORY:   mem_addr_q[free_idx_q] <= addr_q;
				BT_HARDWARE: hw_addr_q[free_idx_q]  <= addr_q;
				default: begin
					watch_addr_q[free_idx_q] <= addr_q;
					watch_ext_q[free_idx_q]  <= size_q;
					watch_kind_q[free_idx_q] <= type_q;
				end
			endcase
		end else if (cmd.update && merge) begin
			// Repeat watch insert: widen extent, mixed types become access watch
			if (size_q > watch_ext_q[hit_idx_q]) begin
				watch_ext_q[hit_idx_q] <= size_q;
			end
			if (type_q != watch_kind_q[hit_idx_q]) begin
				watch_kind_q[hit_idx_q] <= BT_ACCESS;
			end
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			success    <= ok;
			slot_index <= slot;
		end
	end

endmodule

@@ rtl/bst_ctrl.sv @@
// Controller: command sequencing and input/output handshakes.
module bst_ctrl import bst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  bst_status_t status,
	output bst_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready    = (state_q == S_IDLE);
	assign out_free    = !out_valid_q || out_ready;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.search  = (state_q == S_SEARCH);
	assign cmd.update  = (state_q == S_UPDATE) && out_free;
	assign out_valid   = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = status.no_search ? S_UPDATE : S_SEARCH;
				end
			end
			S_SEARCH: state_d = S_UPDATE;
			S_UPDATE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_SEARCH || state_q == S_UPDATE))
		else $error("accepted word did not start processing");

	a_valid_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_UPDATE))
		else $error("result valid raised outside update");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.update)
		else $error("pending result word overwritten");

	a_search_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search |=> (state_q == S_UPDATE))
		else $error("search not followed by update");
`endif

endmodule

@@ rtl/breakpoint_slot_table_unit.sv @@
// Sequence: a command word is captured, then searched in the registered search step, then
// applied in the table-update step of the controller, which also registers the result word;
// a clear or an invalid kind or type skips the search. The update waits while a pending
// result word is not taken, and a new command word is accepted only after that update.
// Reset (arst_n low): all slot valid bits and both slot counts clear to zero,
// controller returns to idle; no clearing pass is needed.
module breakpoint_slot_table_unit import bst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KIND_W-1:0]     kind,
	input  logic [TYPE_W-1:0]     break_type,
	input  logic [ADDR_W-1:0]     target_address,
	input  logic [SIZE_W-1:0]     watch_size,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  success,
	output logic [SLOT_W-1:0]     slot_index
);

	bst_cmd_t    cmd;
	bst_status_t status;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	bst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bst_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.break_type     (break_type),
		.target_address (target_address),
		.watch_size     (watch_size),
		.success        (success),
		.slot_index     (slot_index)
	);

endmodule
